[src/ccs_pkg.sv]
// ============================================================================
// ccs_pkg - shared types for the C comment stripper
// Scan modes, result command encoding and the character constants.
// ============================================================================
package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_BSTAR  = 3'd4
    } scan_mode_t;

    // OP_ONE: one result (data, present). OP_TWO: a slash, then data.
    typedef enum logic {
        OP_ONE = 1'b0,
        OP_TWO = 1'b1
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic       present;
        logic       last;
    } cmd_t;

endpackage

[src/ccs_front.sv]
// ============================================================================
// ccs_front - input side of the comment stripper
// Accepts text items, runs the scan state machine, queues result commands.
// ============================================================================
module ccs_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          q_full,
    output logic          push,
    output ccs_pkg::cmd_t push_cmd
);

    ccs_pkg::scan_mode_t mode_reg;
    ccs_pkg::scan_mode_t mode_next;
    ccs_pkg::scan_mode_t mode_step;
    logic                accept;
    logic                emit_one;
    logic                emit_two;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ccs_pkg::MODE_NORMAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        mode_step = mode_reg;
        emit_one  = 1'b0;
        emit_two  = 1'b0;
        unique case (mode_reg)
            ccs_pkg::MODE_SLASH:
            begin
                if (s_tdata == ccs_pkg::CH_SLASH)
                begin
                    mode_step = ccs_pkg::MODE_LINE;
                end
                else if (s_tdata == ccs_pkg::CH_STAR)
                begin
                    mode_step = ccs_pkg::MODE_BLOCK;
                end
                else
                begin
                    emit_two  = 1'b1;
                    mode_step = ccs_pkg::MODE_NORMAL;
                end
            end
            ccs_pkg::MODE_LINE:
            begin
                if (s_tdata == ccs_pkg::CH_NL)
                begin
                    mode_step = ccs_pkg::MODE_NORMAL;
                end
            end
            ccs_pkg::MODE_BLOCK:
            begin
                if (s_tdata == ccs_pkg::CH_STAR)
                begin
                    mode_step = ccs_pkg::MODE_BSTAR;
                end
            end
            ccs_pkg::MODE_BSTAR:
            begin
                if (s_tdata == ccs_pkg::CH_SLASH)
                begin
                    mode_step = ccs_pkg::MODE_NORMAL;
                end
                else if (s_tdata != ccs_pkg::CH_STAR)
                begin
                    mode_step = ccs_pkg::MODE_BLOCK;
                end
            end
            default:
            begin
                if (s_tdata == ccs_pkg::CH_SLASH)
                begin
                    mode_step = ccs_pkg::MODE_SLASH;
                end
                else
                begin
                    emit_one  = 1'b1;
                    mode_step = ccs_pkg::MODE_NORMAL;
                end
            end
        endcase

        push_cmd.op      = emit_two ? ccs_pkg::OP_TWO : ccs_pkg::OP_ONE;
        push_cmd.data    = s_tdata;
        push_cmd.present = 1'b1;
        push_cmd.last    = 1'b0;
        push             = accept && (emit_one || emit_two);
        mode_next        = mode_step;

        if (s_tlast)
        begin
            push_cmd.last = 1'b1;
            mode_next     = ccs_pkg::MODE_NORMAL;
            if (mode_step == ccs_pkg::MODE_SLASH)
            begin
                // slash held by the final byte is flushed alone
                push_cmd.op   = ccs_pkg::OP_ONE;
                push_cmd.data = ccs_pkg::CH_SLASH;
                push          = accept;
            end
            else if (!(emit_one || emit_two))
            begin
                // empty end marker
                push_cmd.op      = ccs_pkg::OP_ONE;
                push_cmd.data    = 8'h00;
                push_cmd.present = 1'b0;
                push             = accept;
            end
        end
    end

endmodule

[src/ccs_queue.sv]
// ============================================================================
// ccs_queue - command queue between front and back
// Small first-in first-out store of result commands.
// ============================================================================
module ccs_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ccs_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output ccs_pkg::cmd_t head_cmd,
    output logic          not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ccs_pkg::cmd_t   entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/ccs_back.sv]
// ============================================================================
// ccs_back - output side of the comment stripper
// Expands queued commands into result items through an output register.
// ============================================================================
module ccs_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  ccs_pkg::cmd_t head_cmd,
    input  logic          not_empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       user_reg;
    logic       last_reg;
    logic       phase_reg;   // 1: leading slash of a two-result command already sent
    logic       load;
    logic       lead_slash;

    assign load       = not_empty && (!valid_reg || m_tready);
    assign lead_slash = (head_cmd.op == ccs_pkg::OP_TWO) && !phase_reg;
    assign pop        = load && !lead_slash;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= lead_slash;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= lead_slash ? ccs_pkg::CH_SLASH : head_cmd.data;
            user_reg <= lead_slash ? 1'b1 : head_cmd.present;
            last_reg <= lead_slash ? 1'b0 : head_cmd.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

[src/c_comment_stripper_unit.sv]
// ============================================================================
// c_comment_stripper_unit - C comment removal on a byte stream
// Drops line and block comments, passes every other byte on in order.
// ============================================================================
// Path: a result shows on m_tvalid after its item is accepted, through the
//   queue write, then the output register load (which waits while stalled).
// Throughput: one item per cycle in, one result per cycle out while not stalled;
//   an item freeing a held slash gives two results; s_tready drops only on a full queue.
// Reset (rst_n, async, active low) returns the scan to normal text mode and
//   empties the queue and output register.
// ============================================================================
module c_comment_stripper_unit
#(
    parameter int QUEUE_DEPTH = 4   // command queue entries, 2 or more
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] text_byte
    input  logic       s_tlast,    // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] kept_byte
    output logic       m_tuser,    // [0] byte_present
    output logic       m_tlast     // last_result
);

    ccs_pkg::cmd_t push_cmd;
    ccs_pkg::cmd_t head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_not_empty;

    // front: scan state machine, one command per item that yields results
    ccs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // queue decouples front stalls from output back-pressure
    ccs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty)
    );

    // back: one result per cycle into the output register while the output is not stalled
    ccs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .not_empty (q_not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[src/ccs_checker.sv]
// ============================================================================
// ccs_checker - port-level checks for the comment stripper
// Watches the stream ports; attached to the top level by bind.
// ============================================================================
module ccs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    logic [7:0] open_texts_reg;   // texts ended at input, final result not yet delivered
    logic       in_end;
    logic       out_end;

    assign in_end  = s_tvalid && s_tready && s_tlast;
    assign out_end = m_tvalid && m_tready && m_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_texts_reg <= '0;
        end
        else if (in_end && !out_end)
        begin
            open_texts_reg <= open_texts_reg + 1'b1;
        end
        else if (out_end && !in_end)
        begin
            open_texts_reg <= open_texts_reg - 1'b1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // empty marker only ends a text and carries a zero byte
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("empty marker malformed");

    // a final result needs a text that ended at the input
    a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_end |-> (open_texts_reg != 8'h00))
        else $error("final result without ended text");

    // after the final result of the only open text, m_tvalid drops or no text stays open
    a_no_result_after_idle_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_end && (open_texts_reg == 8'h01) && !in_end |=> !m_tvalid || (open_texts_reg == 8'h00))
        else $error("result after last text closed");

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[dv/comment_strip_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// comment_strip_checker - scoreboard for the C comment stripper
// Predicts the kept bytes of each accepted item and checks each output item.
// ============================================================================
module comment_strip_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         kept_pending
);

    typedef struct {
        logic [7:0] kept_byte;
        logic       byte_present;
        logic       last_result;
    } kept_item_t;

    ccs_pkg::scan_mode_t strip_mode;
    kept_item_t          kept_q[$];
    int                  errs;

    task automatic push_kept(ref kept_item_t step_q[$], input logic [7:0] b,
                             input logic present);
        kept_item_t r;
        r.kept_byte    = b;
        r.byte_present = present;
        r.last_result  = 1'b0;
        step_q.push_back(r);
    endtask

    // one input item -> zero, one or two kept items
    task automatic predict_strip(input logic [7:0] c, input logic eot);
        kept_item_t step_q[$];
        case (strip_mode)
            ccs_pkg::MODE_SLASH:
                if (c == ccs_pkg::CH_SLASH)
                    strip_mode = ccs_pkg::MODE_LINE;
                else if (c == ccs_pkg::CH_STAR)
                    strip_mode = ccs_pkg::MODE_BLOCK;
                else
                begin
                    push_kept(step_q, ccs_pkg::CH_SLASH, 1'b1);
                    push_kept(step_q, c, 1'b1);
                    strip_mode = ccs_pkg::MODE_NORMAL;
                end
            ccs_pkg::MODE_LINE:
                if (c == ccs_pkg::CH_NL)
                    strip_mode = ccs_pkg::MODE_NORMAL;
            ccs_pkg::MODE_BLOCK:
                if (c == ccs_pkg::CH_STAR)
                    strip_mode = ccs_pkg::MODE_BSTAR;
            ccs_pkg::MODE_BSTAR:
                if (c == ccs_pkg::CH_SLASH)
                    strip_mode = ccs_pkg::MODE_NORMAL;
                else if (c != ccs_pkg::CH_STAR)
                    strip_mode = ccs_pkg::MODE_BLOCK;
            default:
                if (c == ccs_pkg::CH_SLASH)
                    strip_mode = ccs_pkg::MODE_SLASH;
                else
                begin
                    push_kept(step_q, c, 1'b1);
                    strip_mode = ccs_pkg::MODE_NORMAL;
                end
        endcase
        if (eot)
        begin
            if (strip_mode == ccs_pkg::MODE_SLASH)
                push_kept(step_q, ccs_pkg::CH_SLASH, 1'b1);
            if (step_q.size() == 0)
                push_kept(step_q, 8'h00, 1'b0);
            step_q[step_q.size() - 1].last_result = 1'b1;
            strip_mode = ccs_pkg::MODE_NORMAL;
        end
        foreach (step_q[i])
            kept_q.push_back(step_q[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kept_item_t exp_item;
        if (!rst_n)
        begin
            strip_mode = ccs_pkg::MODE_NORMAL;
            kept_q.delete();
            errs = 0;
        end
        else
        begin
            // output side first: an item accepted now cannot show at this edge
            if (m_tvalid && m_tready)
            begin
                if (kept_q.size() == 0)
                begin
                    $error("unexpected output item: kept_byte %h byte_present %b last %b",
                           m_tdata, m_tuser, m_tlast);
                    errs++;
                end
                else
                begin
                    exp_item = kept_q.pop_front();
                    if (m_tdata !== exp_item.kept_byte)
                    begin
                        $error("kept_byte: expected %h, actual %h",
                               exp_item.kept_byte, m_tdata);
                        errs++;
                    end
                    if (m_tuser !== exp_item.byte_present)
                    begin
                        $error("byte_present: expected %b, actual %b",
                               exp_item.byte_present, m_tuser);
                        errs++;
                    end
                    if (m_tlast !== exp_item.last_result)
                    begin
                        $error("last_result: expected %b, actual %b",
                               exp_item.last_result, m_tlast);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_strip(s_tdata, s_tlast);
        end
        fail_count   <= errs;
        kept_pending <= kept_q.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench - stream test of c_comment_stripper_unit
// Directed texts for the comment corner cases, then random texts built from
// comments, slashes, stars and noise under three idle patterns; a separate
// checker predicts and compares every output item.
// ============================================================================
module testbench;

    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no handshake at all
    localparam int ITEMS_PER_PHASE = 400;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;            // [7:0] text_byte
    logic       s_tlast = 1'b0;             // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;                    // [7:0] kept_byte
    logic       m_tuser;                    // [0] byte_present
    logic       m_tlast;                    // last_result

    int fail_count;
    int kept_pending;
    int src_idle_pct = 35;
    int sink_idle_pct = 60;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    c_comment_stripper_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    comment_strip_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .kept_pending (kept_pending)
    );

    // receiver: random backpressure, one update per falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // watchdog: any handshake on either side restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Only one assignment to s_tvalid per step, so back-to-back items keep
    // valid high without a glitch.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i], i == s.len() - 1);
    endtask

    // biased toward the characters the scanner reacts to
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return ccs_pkg::CH_SLASH;
        else if (r < 38)
            return ccs_pkg::CH_STAR;
        else if (r < 48)
            return ccs_pkg::CH_NL;
        else if (r < 85)
            return 8'h61 + 8'($urandom_range(0, 25));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // one text: a few pieces of plain code, comments (some left open),
    // lone slashes and raw noise; the final byte carries end_of_text
    task automatic send_random_text(output int n_sent);
        logic [7:0] txt[$];
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 5))
                0: repeat ($urandom_range(1, 6))
                    txt.push_back(pick_char());
                1:
                begin
                    txt.push_back(ccs_pkg::CH_SLASH);
                    txt.push_back(ccs_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 6))
                        txt.push_back(pick_char());
                    if ($urandom_range(0, 3) != 0)
                        txt.push_back(ccs_pkg::CH_NL);
                end
                2, 3:
                begin
                    txt.push_back(ccs_pkg::CH_SLASH);
                    txt.push_back(ccs_pkg::CH_STAR);
                    repeat ($urandom_range(0, 6))
                        txt.push_back(pick_char());
                    if ($urandom_range(0, 4) != 0)
                    begin
                        repeat ($urandom_range(1, 3))
                            txt.push_back(ccs_pkg::CH_STAR);
                        txt.push_back(ccs_pkg::CH_SLASH);
                    end
                end
                4:
                begin
                    txt.push_back(ccs_pkg::CH_SLASH);
                    txt.push_back(pick_char());
                end
                default: repeat ($urandom_range(1, 4))
                    txt.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        foreach (txt[i])
            send_byte(txt[i], i == txt.size() - 1);
        n_sent = txt.size();
    endtask

    // sender holds off until every predicted item has come out
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (kept_pending != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int sent;
        int n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: byte extremes, held slash released by the final byte,
        // byte right after a line comment, slash-star-slash not closing a
        // block, star run before the close, slash flushed at end of text,
        // unterminated block and line comments (empty end marker)
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("a/b");
        send_text("//x\nq");
        send_text("/*/**/z");
        send_text("x/");
        send_text("/*a");
        send_text("//");
        drain_outputs();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 35;
                    sink_idle_pct = 60;
                end
                1:
                begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 35;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                send_random_text(n);
                sent += n;
            end
            drain_outputs();
        end

        // idle on in case the block emits anything unpredicted
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[c_comment_stripper_unit.f]
src/ccs_pkg.sv
src/ccs_front.sv
src/ccs_queue.sv
src/ccs_back.sv
src/c_comment_stripper_unit.sv
src/ccs_checker.sv
dv/comment_strip_checker.sv
dv/testbench.sv
